### design/wlpm_pkg.sv
`timescale 1ns / 1ps

package wlpm_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned LATE_W   = 32;

  // One summary after every SUMMARY_EVERY samples
  localparam int unsigned SUMMARY_EVERY = 16;
  localparam int unsigned PHASE_W       = 4;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SUMMARY_EVERY - 1);

  // p99 rank: k = m - floor((m + P99_BIAS) / P99_DIV), m = n - 1
  localparam int unsigned P99_DIV  = 100;
  localparam int unsigned P99_BIAS = 49;

  // Order statistics handed from the selector to the top level
  typedef struct packed {
    logic [SAMPLE_W-1:0] median;
    logic [SAMPLE_W-1:0] p99;
    logic [SAMPLE_W-1:0] max;
  } wlpm_stats_t;

endpackage

### design/wlpm_ring_mem.sv
`timescale 1ns / 1ps

module wlpm_ring_mem
  import wlpm_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // Sample store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/wlpm_select.sv
`timescale 1ns / 1ps

module wlpm_select
  import wlpm_pkg::*;
#(
  parameter int unsigned WINDOW = 64,
  parameter int unsigned AW     = 6,
  parameter int unsigned CW     = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CW-1:0]       fill_i,
  input  logic                ack_i,
  output logic                done_o,
  output wlpm_stats_t         stats_o,
  output logic [AW-1:0]       raddr_o,
  input  logic [SAMPLE_W-1:0] rdata_i
);

  localparam int unsigned RW = $clog2(WINDOW + P99_BIAS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RANK = 3'd1;
  localparam logic [2:0] S_CAND = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       k50_q, k50_d;
  logic [CW-1:0]       k99_q, k99_d;
  logic [RW-1:0]       rem_q, rem_d;
  logic [AW-1:0]       cand_idx_q, cand_idx_d;
  logic [AW-1:0]       scan_idx_q, scan_idx_d;
  logic [CW-1:0]       lt_q, lt_d;
  logic [CW-1:0]       eq_q, eq_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic                cand_ld_q, cand_ld_d;
  logic [SAMPLE_W-1:0] cand_val_q;
  logic [SAMPLE_W-1:0] med_q, p99_q, max_q;

  logic [CW-1:0] n_last;
  logic [CW-1:0] lt_eq;
  logic          scan_last, cand_last;
  logic          hit50, hit99, hitmax;

  assign n_last    = n_q - CW'(1);
  assign scan_last = (CW'(scan_idx_q) == n_last);
  assign cand_last = (CW'(cand_idx_q) == n_last);
  assign lt_eq     = lt_q + eq_q;

  // Candidate holds rank k when k lies in [lt, lt + eq)
  assign hit50  = (lt_q <= k50_q) && (k50_q < lt_eq);
  assign hit99  = (lt_q <= k99_q) && (k99_q < lt_eq);
  assign hitmax = (lt_q <= n_last) && (n_last < lt_eq);

  // Sequencer: rank set-up, then one full scan of the filled entries per candidate
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    k50_d      = k50_q;
    k99_d      = k99_q;
    rem_d      = rem_q;
    cand_idx_d = cand_idx_q;
    scan_idx_d = scan_idx_q;
    lt_d       = lt_q;
    eq_d       = eq_q;
    cmp_vld_d  = 1'b0;
    cand_ld_d  = 1'b0;
    raddr_o    = scan_idx_q;

    // accumulate compare results as the scan data returns
    if (cmp_vld_q) begin
      if (rdata_i < cand_val_q) begin
        lt_d = lt_q + CW'(1);
      end else if (rdata_i == cand_val_q) begin
        eq_d = eq_q + CW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d     = fill_i;
          k50_d   = fill_i >> 1;
          k99_d   = fill_i - CW'(1);
          rem_d   = RW'(fill_i) - RW'(1) + RW'(P99_BIAS);
          state_d = S_RANK;
        end
      end
      S_RANK: begin
        // short repeated subtraction for the p99 rank correction
        if (rem_q >= RW'(P99_DIV)) begin
          rem_d = rem_q - RW'(P99_DIV);
          k99_d = k99_q - CW'(1);
        end else begin
          cand_idx_d = '0;
          state_d    = S_CAND;
        end
      end
      S_CAND: begin
        raddr_o    = cand_idx_q;
        cand_ld_d  = 1'b1;
        scan_idx_d = '0;
        lt_d       = '0;
        eq_d       = '0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        raddr_o   = scan_idx_q;
        cmp_vld_d = 1'b1;
        if (scan_last) begin
          state_d = S_TAIL;
        end else begin
          scan_idx_d = scan_idx_q + AW'(1);
        end
      end
      S_TAIL: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (cand_last) begin
          state_d = S_DONE;
        end else begin
          // fetch the next candidate straight away
          cand_idx_d = cand_idx_q + AW'(1);
          raddr_o    = cand_idx_q + AW'(1);
          cand_ld_d  = 1'b1;
          scan_idx_d = '0;
          lt_d       = '0;
          eq_d       = '0;
          state_d    = S_SCAN;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      n_q        <= '0;
      k50_q      <= '0;
      k99_q      <= '0;
      rem_q      <= '0;
      cand_idx_q <= '0;
      scan_idx_q <= '0;
      lt_q       <= '0;
      eq_q       <= '0;
      cmp_vld_q  <= 1'b0;
      cand_ld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      k50_q      <= k50_d;
      k99_q      <= k99_d;
      rem_q      <= rem_d;
      cand_idx_q <= cand_idx_d;
      scan_idx_q <= scan_idx_d;
      lt_q       <= lt_d;
      eq_q       <= eq_d;
      cmp_vld_q  <= cmp_vld_d;
      cand_ld_q  <= cand_ld_d;
    end
  end

  // Candidate capture and result registers
  always_ff @(posedge clk_i) begin
    if (cand_ld_q) begin
      cand_val_q <= rdata_i;
    end
    if (state_q == S_EVAL) begin
      if (hit50) begin
        med_q <= cand_val_q;
      end
      if (hit99) begin
        p99_q <= cand_val_q;
      end
      if (hitmax) begin
        max_q <= cand_val_q;
      end
    end
  end

  assign done_o         = (state_q == S_DONE);
  assign stats_o.median = med_q;
  assign stats_o.p99    = p99_q;
  assign stats_o.max    = max_q;

  // A candidate always matches itself, so a finished scan saw at least one equal
  a_self_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> (eq_q != '0) && (lt_eq <= n_q))
    else $error("scan count mismatch for candidate");

  // Ranks are in range and ordered once set up
  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CAND |-> (k99_q < n_q) && (k50_q <= k99_q))
    else $error("order statistic ranks out of range");

  // Finished statistics are ordered
  a_stats_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (max_q >= p99_q) && (p99_q >= med_q))
    else $error("statistics out of order");

  // Compare data only follows a scan read
  a_cmp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> $past(state_q) == S_SCAN)
    else $error("compare without scan read");

endmodule

### design/windowed_latency_percentile_monitor_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | latency_us_i, frame_period_us_i
// out     | output    | out_valid_o/out_ready_i | median_us_o, p99_us_o, max_us_o, late_total_o
//
// A request without a summary leaves in_ready_o high.
// Every 16th request starts a rank scan over n filled entries (n <= WINDOW); each
// candidate is compared against every entry through the single read port of the
// sample memory. in_ready_o is low meanwhile.
// The result register holds a summary while the next 15 requests are taken; a
// further summary waits in the selector until out_ready_i frees the register.
// Reset clears counters and control; the sample memory is not cleared.

module windowed_latency_percentile_monitor_core
  import wlpm_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] latency_us_i,
  input  logic [SAMPLE_W-1:0] frame_period_us_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] median_us_o,
  output logic [SAMPLE_W-1:0] p99_us_o,
  output logic [SAMPLE_W-1:0] max_us_o,
  output logic [LATE_W-1:0]   late_total_o
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);

  logic [AW-1:0]      slot_q, slot_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [LATE_W-1:0]  late_q, late_d;
  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;

  logic [SAMPLE_W-1:0] med_q, p99_q, max_q;
  logic [LATE_W-1:0]   late_out_q;

  logic                acc, is_late, start, out_free, load;
  logic                sel_done;
  wlpm_stats_t         sel_stats;
  logic [AW-1:0]       raddr;
  logic [SAMPLE_W-1:0] rdata;

  assign in_ready_o = !busy_q;
  assign acc        = in_valid_i && in_ready_o;
  assign is_late    = (frame_period_us_i != '0) && (latency_us_i > frame_period_us_i);
  assign start      = acc && (phase_q == PHASE_LAST);
  assign out_free   = !out_valid_q || out_ready_i;
  assign load       = sel_done && out_free;

  // Ring pointer, fill level, summary phase, late count, busy flag and output valid
  always_comb begin
    slot_d      = slot_q;
    fill_d      = fill_q;
    phase_d     = phase_q;
    late_d      = late_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (acc) begin
      slot_d  = (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + AW'(1);
      fill_d  = (fill_q < CW'(WINDOW)) ? fill_q + CW'(1) : fill_q;
      phase_d = phase_q + PHASE_W'(1);
      if (is_late) begin
        late_d = late_q + LATE_W'(1);
      end
    end
    if (start) begin
      busy_d = 1'b1;
    end else if (load) begin
      busy_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      late_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      late_q      <= late_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register; late count is stable while a scan runs
  always_ff @(posedge clk_i) begin
    if (load) begin
      med_q      <= sel_stats.median;
      p99_q      <= sel_stats.p99;
      max_q      <= sel_stats.max;
      late_out_q <= late_q;
    end
  end

  wlpm_ring_mem #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (slot_q),
    .wdata_i (latency_us_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  wlpm_select #(
    .WINDOW (WINDOW),
    .AW     (AW),
    .CW     (CW)
  ) u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .fill_i  (fill_d),
    .ack_i   (load),
    .done_o  (sel_done),
    .stats_o (sel_stats),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign median_us_o  = med_q;
  assign p99_us_o     = p99_q;
  assign max_us_o     = max_q;
  assign late_total_o = late_out_q;

endmodule
